// File: design/etl_pkg.sv
package etl_pkg;

    localparam int NUMBER_BITS_DFLT = 31;
    localparam int CODE_BITS        = 5;
    localparam int VALUE_BITS       = 31;
    localparam int IN_TDATA_BITS    = 8;
    localparam int OUT_TDATA_BITS   = 40;
    localparam int OUT_PAD_BITS     = OUT_TDATA_BITS - CODE_BITS - VALUE_BITS - 1;
    localparam int TOK_FIFO_DEPTH   = 4;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [CODE_BITS-1:0] {
        TK_END    = 5'd0,
        TK_LP     = 5'd1,
        TK_RP     = 5'd2,
        TK_MINUS  = 5'd3,
        TK_PLUS   = 5'd4,
        TK_MUL    = 5'd5,
        TK_DIV    = 5'd6,
        TK_MOD    = 5'd7,
        TK_GT     = 5'd8,
        TK_GE     = 5'd9,
        TK_EQ     = 5'd10,
        TK_LT     = 5'd11,
        TK_LE     = 5'd12,
        TK_NE     = 5'd13,
        TK_NOT    = 5'd14,
        TK_NUMBER = 5'd15,
        TK_JUNK   = 5'd16
    } t_tok_code;

    // first character of a possible two-character operator
    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_GT   = 3'd1,
        PEND_EQ   = 3'd2,
        PEND_LT   = 3'd3,
        PEND_BANG = 3'd4
    } t_pend;

    typedef struct packed {
        t_tok_code              code;
        logic [VALUE_BITS-1:0]  value;
        logic                   ovf;
        logic                   last;
    } t_token;

    // up to two tokens written to the output buffer in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic t_token mk_tok(t_tok_code code, logic [VALUE_BITS-1:0] value,
                                      logic ovf);
        t_token t;
        t.code  = code;
        t.value = value;
        t.ovf   = ovf;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

// File: design/expression_token_lexer_top.sv
// Expression lexer: text bytes in, tokens out.
// Slave channel: one text byte per request on i_s_tdata; a zero byte ends
// the text, emits the end token and returns the lexer to its reset state.
// Master channel: one token per request. o_m_tdata carries code, number
// value and overflow flag; o_m_tlast marks the final token caused by a byte.
// A byte yields zero, one or two tokens (two when it closes a pending
// operator or number and also forms a token of its own).
// Path: an accepted byte passes the input register, then the lexer step that
// writes the token buffer, before its first token can be taken.
// Throughput: one byte per cycle while each byte yields at most one token
// and i_m_tready is high; a two-token byte sends its tokens one by one
// through the single output port that drains the four-entry token buffer.
// Backpressure: when i_m_tready is low the buffer fills, the input register
// holds its byte and o_s_tready drops; nothing is lost or reordered.
// Reset (synchronous, active low) empties the buffer and clears lexer state.
module expression_token_lexer_top #(
    parameter int NUMBER_BITS = etl_pkg::NUMBER_BITS_DFLT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [etl_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,   // [7:0] text_byte
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [etl_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,   // [4:0] token_code,
                                                            // [35:5] number_value,
                                                            // [36] number_overflow,
                                                            // [39:37] zero
    output logic                               o_m_tlast    // last_of_run
);
    import etl_pkg::*;

    logic                     r_in_valid;
    logic [IN_TDATA_BITS-1:0] r_in_byte;
    logic                     w_room;
    logic                     w_step;
    t_push                    w_push;
    t_token                   w_tok;

    assign w_step     = r_in_valid && w_room;
    assign o_s_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    etl_lexer #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_push  (w_push)
    );

    etl_tok_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_tok       (w_tok),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = {{OUT_PAD_BITS{1'b0}}, w_tok.ovf, w_tok.value, w_tok.code};
    assign o_m_tlast = w_tok.last;

endmodule

// File: design/etl_lexer.sv
module etl_lexer #(
    parameter int NUMBER_BITS = etl_pkg::NUMBER_BITS_DFLT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [etl_pkg::IN_TDATA_BITS-1:0] i_byte,
    output etl_pkg::t_push                   o_push
);
    import etl_pkg::*;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    t_pend                  r_pend, n_pend;
    logic                   r_num_act, n_num_act;
    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic                   r_sat, n_sat;

    logic                              w_digit;
    logic [NUMBER_BITS+3:0]            w_acc_ext;
    logic [NUMBER_BITS+3:0]            w_prod;
    logic [NUMBER_BITS+VALUE_BITS-1:0] w_val_ext;
    logic                              w_hit;
    t_tok_code                         w_two;
    logic                              w_run_norm;
    logic                              w_pre_has, w_norm_has;
    t_token                            w_pre_tok, w_norm_tok;
    logic [1:0]                        w_cnt;

    function automatic t_tok_code single_of(t_pend p);
        t_tok_code c;
        unique case (p)
            PEND_GT: c = TK_GT;
            PEND_EQ: c = TK_EQ;
            PEND_LT: c = TK_LT;
            default: c = TK_NOT;
        endcase
        return c;
    endfunction

    assign w_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_acc_ext = {4'b0000, r_acc};
    // acc * 10 + digit; fits when the top four bits stay clear
    assign w_prod    = (w_acc_ext << 3) + (w_acc_ext << 1)
                     + {{NUMBER_BITS{1'b0}}, i_byte[3:0]};
    assign w_val_ext = {{VALUE_BITS{1'b0}}, r_acc};

    always_comb begin
        n_pend     = r_pend;
        n_num_act  = r_num_act;
        n_acc      = r_acc;
        n_sat      = r_sat;
        w_hit      = 1'b0;
        w_two      = TK_END;
        w_run_norm = 1'b1;
        w_pre_has  = 1'b0;
        w_pre_tok  = mk_tok(TK_END, '0, 1'b0);
        w_norm_has = 1'b0;
        w_norm_tok = mk_tok(TK_END, '0, 1'b0);

        if (r_pend != PEND_NONE) begin
            n_pend = PEND_NONE;
            if (i_byte == CH_EQ) begin
                w_hit = 1'b1;
                unique case (r_pend)
                    PEND_GT: w_two = TK_GE;
                    PEND_EQ: w_two = TK_EQ;
                    PEND_LT: w_two = TK_LE;
                    default: w_two = TK_NE;
                endcase
            end else if (i_byte == CH_GT && r_pend == PEND_LT) begin
                w_hit = 1'b1;
                w_two = TK_NE;
            end
            w_pre_has = 1'b1;
            if (w_hit) begin
                w_pre_tok  = mk_tok(w_two, '0, 1'b0);
                w_run_norm = 1'b0;
            end else begin
                w_pre_tok = mk_tok(single_of(r_pend), '0, 1'b0);
            end
        end else if (r_num_act) begin
            if (w_digit) begin
                w_run_norm = 1'b0;
                if (!r_sat && w_prod[NUMBER_BITS+3:NUMBER_BITS] == 4'b0000) begin
                    n_acc = w_prod[NUMBER_BITS-1:0];
                end else begin
                    n_acc = NUM_MAX;
                    n_sat = 1'b1;
                end
            end else begin
                w_pre_has = 1'b1;
                w_pre_tok = mk_tok(TK_NUMBER, w_val_ext[VALUE_BITS-1:0], r_sat);
                n_num_act = 1'b0;
                n_acc     = '0;
                n_sat     = 1'b0;
            end
        end

        if (w_run_norm) begin
            unique case (i_byte) inside
                CH_NUL: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_END, '0, 1'b0);
                    n_pend     = PEND_NONE;
                    n_num_act  = 1'b0;
                    n_acc      = '0;
                    n_sat      = 1'b0;
                end
                CH_LPAR: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_LP, '0, 1'b0);
                end
                CH_RPAR: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_RP, '0, 1'b0);
                end
                CH_MINUS: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_MINUS, '0, 1'b0);
                end
                CH_PLUS: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_PLUS, '0, 1'b0);
                end
                CH_STAR: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_MUL, '0, 1'b0);
                end
                CH_SLASH: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_DIV, '0, 1'b0);
                end
                CH_PCT: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_MOD, '0, 1'b0);
                end
                CH_GT:   n_pend = PEND_GT;
                CH_EQ:   n_pend = PEND_EQ;
                CH_LT:   n_pend = PEND_LT;
                CH_BANG: n_pend = PEND_BANG;
                CH_SPACE, CH_TAB, CH_NL, CH_FF: begin
                end
                [CH_ZERO:CH_NINE]: begin
                    n_num_act = 1'b1;
                    n_acc     = {{(NUMBER_BITS-4){1'b0}}, i_byte[3:0]};
                    n_sat     = 1'b0;
                end
                default: begin
                    w_norm_has = 1'b1;
                    w_norm_tok = mk_tok(TK_JUNK, '0, 1'b0);
                end
            endcase
        end
    end

    always_comb begin
        w_cnt = {1'b0, w_pre_has} + {1'b0, w_norm_has};
        o_push.count = i_step ? w_cnt : 2'd0;
        if (w_pre_has) begin
            o_push.tok0      = w_pre_tok;
            o_push.tok0.last = !w_norm_has;
        end else begin
            o_push.tok0      = w_norm_tok;
            o_push.tok0.last = 1'b1;
        end
        o_push.tok1      = w_norm_tok;
        o_push.tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= PEND_NONE;
            r_num_act <= 1'b0;
            r_acc     <= '0;
            r_sat     <= 1'b0;
        end else if (i_step) begin
            r_pend    <= n_pend;
            r_num_act <= n_num_act;
            r_acc     <= n_acc;
            r_sat     <= n_sat;
        end
    end

    a_pend_num_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend != PEND_NONE && r_num_act))
        else $error("pending operator and open number at once");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte == CH_NUL) |=>
            (r_pend == PEND_NONE && !r_num_act && r_acc == '0 && !r_sat))
        else $error("end of text left lexer state behind");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_acc == NUM_MAX))
        else $error("saturated accumulator not at maximum");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (!o_push.tok0.last && o_push.tok1.last))
        else $error("last flag misplaced in token pair");

endmodule

// File: design/etl_tok_fifo.sv
module etl_tok_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  etl_pkg::t_push  i_push,
    output logic            o_room,
    output etl_pkg::t_token o_tok,
    output logic            o_valid,
    input  logic            i_pop_ready
);
    import etl_pkg::*;

    localparam int TW = $clog2(TOK_FIFO_DEPTH);

    t_token        r_mem [TOK_FIFO_DEPTH];
    logic [TW-1:0] r_head, r_tail;
    logic [TW:0]   r_count, n_count;
    logic          w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_pop_ready;
    assign o_tok   = r_mem[r_head];
    // room for a full pair of tokens
    assign o_room  = (r_count <= (TW+1)'(TOK_FIFO_DEPTH - 2));
    assign n_count = r_count + (TW+1)'(i_push.count) - (TW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_tail + 1'b1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + TW'(i_push.count);
            r_head  <= r_head + TW'(w_pop);
            r_count <= n_count;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (TW+1)'(TOK_FIFO_DEPTH))
        else $error("token buffer overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("tokens written without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("token count off after read");

endmodule
